>>> src/gnclt_pkg.sv
// ----------------------------------------------------------------------------
// gnclt_pkg
// shared types and constants of the central limit gaussian noise generator
// ----------------------------------------------------------------------------
package gnclt_pkg;

    localparam int SEED_W   = 16;
    localparam int CFG_W    = 16;
    localparam int SUM_W    = 20;
    localparam int CENT_W   = 20;
    localparam int PROD_W   = 37;
    localparam int SAMPLE_W = 20;
    localparam int DRAWS    = 12;
    localparam int CNT_W    = 4;

    // lcg constants, only the low 16 bits take part
    localparam logic [SEED_W-1:0] LCG_MUL = 16'd2053;
    localparam logic [SEED_W-1:0] LCG_ADD = 16'd13849;

    // six times one in 16 fraction bits
    localparam logic signed [SUM_W:0] CENTER_OFFSET = 21'sd393216;

    localparam logic [CNT_W-1:0] LAST_DRAW = CNT_W'(DRAWS - 1);

    // operation codes of an input transaction
    localparam logic OP_GEN  = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // register indexes of the configuration port
    localparam logic REG_MEAN  = 1'b0;
    localparam logic REG_SCALE = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_seed;
        logic clear_sum;
        logic step;
        logic mul;
        logic finish;
    } dp_cmd_t;

endpackage

>>> src/gnclt_dp.sv
// ----------------------------------------------------------------------------
// gnclt_dp
// datapath: lcg step unit, sum accumulator, multiplier and output adder
// ----------------------------------------------------------------------------
module gnclt_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_en,
    input  logic                                   cfg_index,
    input  logic [gnclt_pkg::CFG_W-1:0]            cfg_data,
    input  gnclt_pkg::dp_cmd_t                     cmd,
    input  logic [gnclt_pkg::SEED_W-1:0]           seed_value,
    output logic signed [gnclt_pkg::SAMPLE_W-1:0]  sample
);

    logic [gnclt_pkg::SEED_W-1:0]          seed_reg;
    logic [gnclt_pkg::SEED_W-1:0]          seed_next;
    logic [gnclt_pkg::SUM_W-1:0]           sum_reg;
    logic [gnclt_pkg::SUM_W-1:0]           sum_next;
    logic signed [gnclt_pkg::CFG_W-1:0]    mean_reg;
    logic [gnclt_pkg::CFG_W-1:0]           scale_reg;
    logic signed [gnclt_pkg::PROD_W-1:0]   prod_reg;
    logic signed [gnclt_pkg::PROD_W-1:0]   prod_next;
    logic signed [gnclt_pkg::SAMPLE_W-1:0] sample_reg;
    logic signed [gnclt_pkg::SAMPLE_W-1:0] sample_next;
    logic signed [gnclt_pkg::SUM_W:0]      cent_wide;
    logic signed [gnclt_pkg::CENT_W-1:0]   centered;
    logic signed [gnclt_pkg::SAMPLE_W+1:0] sample_wide;

    // one lcg draw a cycle while step is set, mod 65536 by truncation
    assign seed_next = seed_reg * gnclt_pkg::LCG_MUL + gnclt_pkg::LCG_ADD;
    assign sum_next  = sum_reg + {{(gnclt_pkg::SUM_W-gnclt_pkg::SEED_W){1'b0}}, seed_next};

    assign cent_wide = $signed({1'b0, sum_reg}) - gnclt_pkg::CENTER_OFFSET;
    assign centered  = cent_wide[gnclt_pkg::CENT_W-1:0];
    assign prod_next = $signed({1'b0, scale_reg}) * centered;

    // arithmetic shift by 16 is the floor shift
    assign sample_wide = {{6{mean_reg[gnclt_pkg::CFG_W-1]}}, mean_reg}
                       + {prod_reg[gnclt_pkg::PROD_W-1], prod_reg[gnclt_pkg::PROD_W-1:16]};
    assign sample_next = sample_wide[gnclt_pkg::SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            mean_reg  <= '0;
            scale_reg <= 16'd256;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                seed_reg <= seed_value;
            end
            else if (cmd.step)
            begin
                seed_reg <= seed_next;
            end
            if (cfg_en)
            begin
                case (cfg_index)
                    gnclt_pkg::REG_MEAN:  mean_reg  <= cfg_data;
                    gnclt_pkg::REG_SCALE: scale_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_sum)
        begin
            sum_reg <= '0;
        end
        else if (cmd.step)
        begin
            sum_reg <= sum_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.finish)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

endmodule

>>> src/gnclt_ctrl.sv
// ----------------------------------------------------------------------------
// gnclt_ctrl
// controller: sequences seed loads, the twelve draws, the multiply and the output load
// ----------------------------------------------------------------------------
module gnclt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    output logic               out_valid,
    input  logic               out_ready,
    output gnclt_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_ADD  = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [gnclt_pkg::CNT_W-1:0] cnt_reg;
    logic [gnclt_pkg::CNT_W-1:0] cnt_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        in_fire;
    logic                        out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == gnclt_pkg::OP_LOAD)
                    begin
                        cmd.load_seed = 1'b1;
                    end
                    else
                    begin
                        cmd.clear_sum = 1'b1;
                        cnt_next      = '0;
                        state_next    = ST_STEP;
                    end
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gnclt_pkg::LAST_DRAW)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_mul_after_last_draw : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |->
            ($past(state_reg) == ST_STEP && $past(cnt_reg) == gnclt_pkg::LAST_DRAW))
        else $error("multiply entered before the twelfth draw");

    a_gen_starts_draws : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == gnclt_pkg::OP_GEN) |=> (state_reg == ST_STEP && cnt_reg == '0))
        else $error("generate transaction did not start the draw sequence");

    a_add_waits_for_room : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && !out_free) |=> (state_reg == ST_ADD))
        else $error("result overwrote a pending output");

    a_finish_gives_valid : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD && out_free) |=> (out_valid && state_reg == ST_IDLE))
        else $error("finished sample not presented");

endmodule

>>> src/gaussian_noise_clt_lcg.sv
// ----------------------------------------------------------------------------
// gaussian_noise_clt_lcg
// gaussian noise sample generator, sum of twelve lcg draws
// ----------------------------------------------------------------------------
//
// channel  direction  handshake            payload
// -------  ---------  -------------------  ------------------------------
// input    in         in_valid / in_ready  op, seed_value
// output   out        out_valid/out_ready  sample (signed q12.8, 20 bits)
// config   in         cfg_en (no wait)     cfg_index, cfg_data
//
// a generate transaction goes from acceptance to the output register
// through twelve steps of the shared lcg step unit (each draw needs the
// previous seed), the multiply state and the add state
// a load transaction loads the seed and gives no result
// reset clears the seed to zero, mean to zero and scale to 1.0
// a stalled output holds the finished sample; a new transaction is taken
// meanwhile and waits in the add cycle only if the output is still full
// ----------------------------------------------------------------------------
module gaussian_noise_clt_lcg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_en,
    input  logic                                   cfg_index,
    input  logic [gnclt_pkg::CFG_W-1:0]            cfg_data,
    // input transactions
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   op,
    input  logic [gnclt_pkg::SEED_W-1:0]           seed_value,
    // result transactions
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [gnclt_pkg::SAMPLE_W-1:0]  sample
);

    // command bundle from the sequencer to the arithmetic
    gnclt_pkg::dp_cmd_t cmd;

    // controller: idle, twelve draws, multiply, output load
    gnclt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // datapath: seed, running sum, config registers, product and sample
    gnclt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .seed_value (seed_value),
        .sample     (sample)
    );

endmodule
